### src/nhist_pkg.sv
// ----------------------------------------------------------------------------
// nhist_pkg
// Shared types and constants of the normalized histogram unit.
// ----------------------------------------------------------------------------
package nhist_pkg;

	localparam int COUNT_W      = 32;
	localparam int BIN_W        = 8;
	localparam int FRAC_BITS    = 16;
	localparam int FRAC_W       = FRAC_BITS + 1;
	localparam int NUM_BINS_DEF = 256;

	localparam logic [COUNT_W-1:0] TOTAL_MAX = {COUNT_W{1'b1}};

	typedef enum logic {
		MODE_ADD   = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t            mode;
		logic [BIN_W-1:0] bin;
	} cmd_t;

	typedef struct packed {
		logic [BIN_W-1:0]  bin_echo;
		logic [FRAC_W-1:0] fraction;
		logic              empty_res;
		logic              overflowed;
	} result_t;

	typedef struct packed {
		logic               start;
		logic [COUNT_W-1:0] count;
		logic [COUNT_W-1:0] total;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [FRAC_W-1:0] quot;
	} div_rsp_t;

endpackage

### src/nhist_ram.sv
// ----------------------------------------------------------------------------
// nhist_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nhist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/nhist_div.sv
// ----------------------------------------------------------------------------
// nhist_div
// Bit-serial restoring divider: (count * 2^16 + total/2) / total, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module nhist_div (
	input  logic                clk,
	input  logic                arst_n,
	input  nhist_pkg::div_req_t req,
	output nhist_pkg::div_rsp_t rsp
);

	localparam int CW    = nhist_pkg::COUNT_W;
	localparam int QW    = nhist_pkg::FRAC_W;
	localparam int NW    = CW + nhist_pkg::FRAC_BITS + 1;
	localparam int STEPS = QW;
	localparam int SCW   = $clog2(STEPS);

	logic [NW-1:0]  num;
	logic [CW-1:0]  rem_q;
	logic [CW-1:0]  den_q;
	logic [QW-1:0]  low_q;
	logic [QW-1:0]  quot_q;
	logic [SCW-1:0] step_q;
	logic           run_q;
	logic           done_q;
	logic [CW:0]    trial;
	logic           take;

	// one spare top bit keeps the rounding term from wrapping near full count
	assign num = {1'b0, req.count, {nhist_pkg::FRAC_BITS{1'b0}}}
		+ NW'(req.total[CW-1:1]);

	assign trial = {rem_q, low_q[QW-1]};
	assign take  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && !req.start && (step_q == '0);
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= SCW'(STEPS - 1);
			end else if (run_q) begin
				if (step_q == '0) begin
					run_q <= 1'b0;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// the top bits of the dividend are already below the divisor
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= CW'(num[NW-1:QW]);
			low_q  <= num[QW-1:0];
			den_q  <= req.total;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= take ? CW'(trial - {1'b0, den_q}) : trial[CW-1:0];
			low_q  <= {low_q[QW-2:0], 1'b0};
			quot_q <= {quot_q[QW-2:0], take};
		end
	end

	assign rsp.busy = run_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

### src/normalized_histogram_unit.sv
// ----------------------------------------------------------------------------
// normalized_histogram_unit
// Histogram of bin counts with queries normalized to the running total.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd and raise start; the beat is taken on a clock edge where start
//   is high and busy is low. An add beat (mode add) bumps the named bin (if in
//   range) and the total, and returns nothing. A query beat returns one beat on
//   result, flagged by done for a single cycle: the bin, its count over the
//   total in unsigned Q1.16, an empty flag and the saturation flag.
//   Adds go one per cycle unless busy: the bin RAM is read on acceptance and
//   written back the next cycle, with a one-entry bypass for a repeated bin.
//   A query holds busy while it runs: first the RAM read, then the bit-serial
//   divider, and done is registered from the divider's done. On an empty
//   histogram the divider is skipped and done comes from the read stage.
//   Once the total reaches its maximum, adds are dropped; the first dropped
//   add sets the overflow flag, which stays set until reset.
//   After reset, busy stays high while a sweep writes zero to every bin.
//   Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module normalized_histogram_unit #(
	parameter int NUM_BINS = nhist_pkg::NUM_BINS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  nhist_pkg::cmd_t    cmd,
	output logic               busy,
	output logic               done,
	output nhist_pkg::result_t result
);

	localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int CW = nhist_pkg::COUNT_W;
	localparam int BW = nhist_pkg::BIN_W;

	logic          accept;
	logic          in_range;
	logic [15:0]   bin_ext;
	logic [AW-1:0] rd_addr;
	logic          do_add;

	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	logic [CW-1:0] total_q;
	logic          sat_q;

	logic                 vld_s1;
	nhist_pkg::mode_t     mode_s1;
	logic                 inr_s1;
	logic [AW-1:0]        addr_s1;
	logic [BW-1:0]        bin_s1;

	logic          wb_vld_q;
	logic [AW-1:0] wb_addr_q;
	logic [CW-1:0] wb_data_q;

	logic [CW-1:0] rdata;
	logic [CW-1:0] count_s1;
	logic [CW-1:0] inc_s1;
	logic          add_s1;
	logic          query_s1;

	logic          we;
	logic [AW-1:0] waddr;
	logic [CW-1:0] wdata;

	logic [BW-1:0] qbin_q;
	logic          qsat_q;

	nhist_pkg::div_req_t div_req;
	nhist_pkg::div_rsp_t div_rsp;

	logic               done_q;
	nhist_pkg::result_t res_q;

	assign accept   = start && !busy;
	assign bin_ext  = 16'(cmd.bin);
	assign rd_addr  = bin_ext[AW-1:0];
	assign in_range = (17'(cmd.bin) < 17'(NUM_BINS));
	assign do_add   = accept && (cmd.mode == nhist_pkg::MODE_ADD) && in_range
		&& (total_q != nhist_pkg::TOTAL_MAX);

	assign add_s1   = vld_s1 && (mode_s1 == nhist_pkg::MODE_ADD);
	assign query_s1 = vld_s1 && (mode_s1 == nhist_pkg::MODE_QUERY);

	// bypass the write that landed in the same cycle as this read
	assign count_s1 = (wb_vld_q && (wb_addr_q == addr_s1)) ? wb_data_q : rdata;
	assign inc_s1   = count_s1 + 1'b1;

	assign busy = clr_q || query_s1 || div_rsp.busy;

	always_comb begin
		if (clr_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we    = add_s1;
			waddr = addr_s1;
			wdata = inc_s1;
		end
	end

	nhist_ram #(
		.WIDTH (CW),
		.DEPTH (NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign div_req.start = query_s1 && (total_q != '0);
	assign div_req.count = inr_s1 ? count_s1 : '0;
	assign div_req.total = total_q;

	nhist_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			total_q    <= '0;
			sat_q      <= 1'b0;
			vld_s1     <= 1'b0;
			wb_vld_q   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(NUM_BINS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (do_add) begin
				total_q <= total_q + 1'b1;
			end else if (accept && (cmd.mode == nhist_pkg::MODE_ADD) && in_range) begin
				sat_q <= 1'b1;
			end
			vld_s1   <= do_add || (accept && (cmd.mode == nhist_pkg::MODE_QUERY));
			wb_vld_q <= add_s1;
			done_q   <= (query_s1 && (total_q == '0)) || div_rsp.done;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= cmd.mode;
			inr_s1  <= in_range;
			addr_s1 <= rd_addr;
			bin_s1  <= cmd.bin;
		end
		if (add_s1) begin
			wb_addr_q <= addr_s1;
			wb_data_q <= inc_s1;
		end
		if (query_s1) begin
			qbin_q <= bin_s1;
			qsat_q <= sat_q;
		end
		// empty histogram answers straight from the read stage
		if (query_s1 && (total_q == '0)) begin
			res_q.bin_echo   <= bin_s1;
			res_q.fraction   <= '0;
			res_q.empty_res  <= 1'b1;
			res_q.overflowed <= sat_q;
		end else if (div_rsp.done) begin
			res_q.bin_echo   <= qbin_q;
			res_q.fraction   <= div_rsp.quot;
			res_q.empty_res  <= 1'b0;
			res_q.overflowed <= qsat_q;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
